// ----- rtl/dhoat_pkg.sv -----
// Shared types, constants and codes of the double-hashing open-address table.
package dhoat_pkg;

  localparam int unsigned SLOTS       = 1024;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned HASH_W      = 31;
  localparam int unsigned IDX_W       = $clog2(SLOTS);
  localparam int unsigned SIZE_W      = IDX_W + 1;
  localparam int unsigned MIN_SIZE    = 3;
  localparam int unsigned SIZE_RESET  = 1023;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned HCNT_W      = $clog2(HASH_W);
  localparam int unsigned PADDR_W     = 3;

  typedef enum logic [1:0] {
    OP_SET      = 2'd0,
    OP_CONTAINS = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_GET      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_LIVE    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  typedef struct packed {
    mark_e                  mark;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] hash;
    logic [SIZE_W-1:0] size;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem_pos;
    logic [IDX_W-1:0] rem_step;
  } mod_rsp_t;

endpackage

// ----- rtl/dhoat_if.sv -----
// Valid/ready channel interfaces for operations and results.
interface dhoat_in_if
  import dhoat_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [KEY_WIDTH-1:0]   key;
  logic [HASH_W-1:0]      key_hash;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, opcode, key, key_hash, value, input ready);
  modport sink   (input valid, opcode, key, key_hash, value, output ready);
endinterface

interface dhoat_out_if
  import dhoat_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic                   found;
  logic [VALUE_WIDTH-1:0] read_value;
  logic [CNT_W-1:0]       live_count;

  modport source (output valid, status, found, read_value, live_count, input ready);
  modport sink   (input valid, status, found, read_value, live_count, output ready);
endinterface

// ----- rtl/dhoat_ram.sv -----
// Generic simple dual-port RAM, registered read.
module dhoat_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 66
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/dhoat_mod.sv -----
// Bit-serial remainder unit: hash mod size and hash mod (size-1) in parallel.
module dhoat_mod
  import dhoat_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);
  logic              busy_q, done_q;
  logic [HCNT_W-1:0] bit_q;
  logic [HASH_W-1:0] sh_q;
  logic [IDX_W-1:0]  r0_q, r1_q, r0_d, r1_d;
  logic [SIZE_W-1:0] d0_q, d1_q, t0, t1;
  logic              last;

  assign last = (bit_q == HCNT_W'(HASH_W - 1));

  always_comb begin
    t0   = {r0_q, sh_q[HASH_W-1]};
    t1   = {r1_q, sh_q[HASH_W-1]};
    r0_d = (t0 >= d0_q) ? IDX_W'(t0 - d0_q) : IDX_W'(t0);
    r1_d = (t1 >= d1_q) ? IDX_W'(t1 - d1_q) : IDX_W'(t1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        bit_q  <= '0;
      end else if (busy_q) begin
        bit_q <= bit_q + HCNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q <= req_i.hash;
      r0_q <= '0;
      r1_q <= '0;
      d0_q <= req_i.size;
      d1_q <= req_i.size - SIZE_W'(1);
    end else if (busy_q) begin
      sh_q <= {sh_q[HASH_W-2:0], 1'b0};
      r0_q <= r0_d;
      r1_q <= r1_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.rem_pos  = r0_q;
  assign rsp_o.rem_step = r1_q;
endmodule

// ----- rtl/double_hash_open_address_table.sv -----
// Top level: double-hashing open-address key/value table.
// An accepted transfer first forms both remainders, one hash bit a cycle, then
//   probes the table (1..size probes, one RAM read each) and loads the result.
// One operation at a time: no new one is accepted until the result is loaded.
// Reset: asynchronous, active low; a clearing pass then marks every slot
//   empty, during which no operation is accepted (APB writes are).
module double_hash_open_address_table
  import dhoat_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  dhoat_in_if.sink           in_s,
  dhoat_out_if.source        out_s,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  state_e state_q, state_d;

  // configuration
  logic [SIZE_W-1:0] tsize_q;
  logic              cfg_we;
  logic [SIZE_W-1:0] size_use;

  // operation context
  op_e                    op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [SIZE_W-1:0]      size_q;
  logic [IDX_W-1:0]       pos_q, pos_d, step_q;
  logic [SIZE_W-1:0]      probe_q, probe_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0]       clr_q;

  // pending result and output register
  status_e                sts_q, sts_d;
  logic                   fnd_q, fnd_d;
  logic [VALUE_WIDTH-1:0] rd_q, rd_d;
  logic                   ov_q, ov_d, out_load;
  status_e                osts_q;
  logic                   ofnd_q;
  logic [VALUE_WIDTH-1:0] ord_q;
  logic [CNT_W-1:0]       ocnt_q;

  // RAM and remainder unit
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_t            ram_wdata, ram_rdata;
  mod_req_t         mreq;
  mod_rsp_t         mrsp;

  logic             accept, key_eq, last_probe;
  logic [SIZE_W-1:0] pos_sum;

  // APB: one register, table_size at byte address 0
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1:2] == '0);
  assign prdata = (paddr[PADDR_W-1:2] == '0) ? 32'(tsize_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q <= SIZE_W'(SIZE_RESET);
    end else if (cfg_we) begin
      tsize_q <= pwdata[SIZE_W-1:0];
    end
  end

  // size in use, clamped to the legal range
  always_comb begin
    if (tsize_q < SIZE_W'(MIN_SIZE)) begin
      size_use = SIZE_W'(MIN_SIZE);
    end else if (tsize_q > SIZE_W'(SLOTS)) begin
      size_use = SIZE_W'(SLOTS);
    end else begin
      size_use = tsize_q;
    end
  end

  assign in_s.ready = (state_q == S_IDLE);
  assign accept     = in_s.valid && in_s.ready;

  assign mreq.start = accept;
  assign mreq.hash  = in_s.key_hash;
  assign mreq.size  = size_use;

  dhoat_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  dhoat_ram #(
    .DEPTH (SLOTS),
    .WIDTH (SLOT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // next probe position: pos + step < 2*size, so one subtract suffices
  assign pos_sum    = {1'b0, pos_q} + {1'b0, step_q};
  assign key_eq     = (ram_rdata.key == key_q);
  assign last_probe = ((probe_q + SIZE_W'(1)) == size_q);

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    probe_d   = probe_q;
    cnt_d     = cnt_q;
    sts_d     = sts_q;
    fnd_d     = fnd_q;
    rd_d      = rd_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = ram_rdata;
    out_load  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we          = 1'b1;
        ram_waddr       = clr_q;
        ram_wdata.mark  = MARK_EMPTY;
        ram_wdata.key   = '0;
        ram_wdata.value = '0;
        if (clr_q == IDX_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (mrsp.done) begin
          pos_d   = mrsp.rem_pos;
          probe_d = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        sts_d = STS_OK;
        fnd_d = 1'b0;
        rd_d  = '0;
        if (op_q == OP_SET) begin
          if (ram_rdata.mark != MARK_LIVE || key_eq) begin
            ram_we          = 1'b1;
            ram_wdata.mark  = MARK_LIVE;
            ram_wdata.key   = key_q;
            ram_wdata.value = val_q;
            if (ram_rdata.mark != MARK_LIVE) begin
              cnt_d = cnt_q + CNT_W'(1);
            end
            fnd_d   = 1'b1;
            state_d = S_DONE;
          end else if (last_probe) begin
            sts_d   = STS_FULL;
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end else begin
          if (ram_rdata.mark == MARK_LIVE && key_eq) begin
            fnd_d   = 1'b1;
            state_d = S_DONE;
            if (op_q == OP_REMOVE) begin
              ram_we         = 1'b1;
              ram_wdata.mark = MARK_DELETED;
              if (cnt_q != '0) begin
                cnt_d = cnt_q - CNT_W'(1);
              end
            end else if (op_q == OP_GET) begin
              rd_d = ram_rdata.value;
            end
          end else if (ram_rdata.mark == MARK_EMPTY || last_probe) begin
            // miss: contains reports ok with found clear
            sts_d   = (op_q == OP_CONTAINS) ? STS_OK : STS_NOT_FOUND;
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
        if (state_d == S_READ) begin
          probe_d = probe_q + SIZE_W'(1);
          pos_d   = (pos_sum >= size_q) ? IDX_W'(pos_sum - size_q) : IDX_W'(pos_sum);
        end
      end
      S_DONE: begin
        if (!ov_q || out_s.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ov_d = out_load || (ov_q && !out_s.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(in_s.opcode);
      key_q  <= in_s.key;
      val_q  <= in_s.value;
      size_q <= size_use;
    end
    if (state_q == S_HASH && mrsp.done) begin
      step_q <= mrsp.rem_step + IDX_W'(1);
    end
    pos_q   <= pos_d;
    probe_q <= probe_d;
    sts_q   <= sts_d;
    fnd_q   <= fnd_d;
    rd_q    <= rd_d;
    if (out_load) begin
      osts_q <= sts_q;
      ofnd_q <= fnd_q;
      ord_q  <= rd_q;
      ocnt_q <= cnt_q;
    end
  end

  assign out_s.valid      = ov_q;
  assign out_s.status     = osts_q;
  assign out_s.found      = ofnd_q;
  assign out_s.read_value = ord_q;
  assign out_s.live_count = ocnt_q;
endmodule
